@@ sv/fsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types and constants for the frame stability detector.
// ----------------------------------------------------------------------------
package fsd_pkg;

    // Detection point store
    localparam int MAX_POINTS = 16384;
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int FILL_W     = PT_W + 1;

    // Field widths
    localparam int PIX_W   = 16;
    localparam int MATCH_W = 15;
    localparam int STAB_W  = 8;
    localparam int SCANS_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAME_THRESHOLD  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_STABLE = 4'd1;

    localparam logic [MATCH_W-1:0] THRESHOLD_RESET = 15'd12400;
    localparam logic [STAB_W-1:0]  REQUIRED_RESET  = 8'd12;

    // Saturation limits and fill color
    localparam logic [PIX_W-1:0]   WHITE565  = 16'hFFFF;
    localparam logic [MATCH_W-1:0] MATCH_MAX = 15'h7FFF;
    localparam logic [STAB_W-1:0]  STAB_MAX  = 8'hFF;
    localparam logic [SCANS_W-1:0] SCANS_MAX = 16'hFFFF;

    // Item kinds
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Classified item handed from front to back
    typedef struct packed {
        logic restart;
        logic last;
        logic match;
    } qent_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic [MATCH_W-1:0] same_threshold;
        logic [STAB_W-1:0]  required_stable;
    } cfg_t;

    // One scan result
    typedef struct packed {
        logic [MATCH_W-1:0] same_count;
        logic               scan_stable;
        logic [STAB_W-1:0]  stable_count;
        logic               finished;
        logic [SCANS_W-1:0] settle_scans;
    } result_t;

endpackage

@@ sv/frame_stability_detector.sv @@
// ----------------------------------------------------------------------------
// frame_stability_detector
// Compares sampled pixels scan against scan and reports when the frame has
// settled. Top level: configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while full is low; the point store does one
// read and one write per sample on a single port, and the queue lets either
// side stall alone. A last-of-scan sample passes the front compare stage, the
// queue and the result register before it shows on the result ports.
// Reset: control state clears at once; stored pixels read as white through a
// fill count, so no clearing pass is needed after reset or restart.
module frame_stability_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               kind,
    input  logic [fsd_pkg::PIX_W-1:0]          pixel_value,
    input  logic                               last_of_scan,
    output logic                               empty,
    input  logic                               pop,
    output logic [fsd_pkg::MATCH_W-1:0]        same_count,
    output logic                               scan_stable,
    output logic [fsd_pkg::STAB_W-1:0]         stable_count,
    output logic                               finished,
    output logic [fsd_pkg::SCANS_W-1:0]        settle_scans,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [fsd_pkg::MATCH_W-1:0] thr_reg;
    logic [fsd_pkg::STAB_W-1:0]  req_reg;
    fsd_pkg::cfg_t               cfg;
    fsd_pkg::qent_t              fq_data;
    fsd_pkg::qent_t              qb_data;
    fsd_pkg::result_t            result;
    logic                        fq_push;
    logic                        fq_full;
    logic                        qb_valid;
    logic                        qb_pop;

    // Configuration writes, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= fsd_pkg::THRESHOLD_RESET;
            req_reg <= fsd_pkg::REQUIRED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fsd_pkg::REG_SAME_THRESHOLD:  thr_reg <= cfg_data[fsd_pkg::MATCH_W-1:0];
                fsd_pkg::REG_REQUIRED_STABLE: req_reg <= cfg_data[fsd_pkg::STAB_W-1:0];
                default:                      ;
            endcase
        end
    end

    assign cfg.same_threshold  = thr_reg;
    assign cfg.required_stable = req_reg;

    fsd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .pixel_value  (pixel_value),
        .last_of_scan (last_of_scan),
        .q_push       (fq_push),
        .q_data       (fq_data),
        .q_full       (fq_full)
    );

    fsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_data),
        .q_full  (fq_full),
        .rd_en   (qb_pop),
        .rd_data (qb_data),
        .q_valid (qb_valid)
    );

    fsd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (qb_valid),
        .q_data  (qb_data),
        .q_pop   (qb_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign same_count   = result.same_count;
    assign scan_stable  = result.scan_stable;
    assign stable_count = result.stable_count;
    assign finished     = result.finished;
    assign settle_scans = result.settle_scans;

    // A finished scan is always a stable one
    a_fin_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && finished) |-> scan_stable)
        else $error("finished reported on an unstable scan");

    // Settle number is only given on the finishing scan
    a_settle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !finished) |-> (settle_scans == '0))
        else $error("settle_scans nonzero without finish");

    // Finish implies the counter reached the required count
    a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && finished && $stable(req_reg)) |-> (stable_count >= req_reg))
        else $error("finished below required stable count");

    // The front never pushes a word into the queue while the queue is full
    a_q_push: assert property (@(posedge clk) disable iff (!rst_n)
        fq_push |-> !fq_full)
        else $error("front pushed into a full queue");

endmodule

@@ sv/fsd_front.sv @@
// ----------------------------------------------------------------------------
// fsd_front
// Accepts samples, tracks the point index, reads and updates the previous
// pixel store and classifies each sample as match or mismatch.
// ----------------------------------------------------------------------------
module fsd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       kind,
    input  logic [fsd_pkg::PIX_W-1:0]  pixel_value,
    input  logic                       last_of_scan,
    output logic                       q_push,
    output fsd_pkg::qent_t             q_data,
    input  logic                       q_full
);

    logic [fsd_pkg::PIX_W-1:0] mem [fsd_pkg::MAX_POINTS];

    logic [fsd_pkg::PT_W-1:0]   point_reg, point_next;
    logic [fsd_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_restart_reg;
    logic                       s1_last_reg;
    logic                       s1_known_reg;
    logic [fsd_pkg::PIX_W-1:0]  s1_pix_reg;
    logic [fsd_pkg::PIX_W-1:0]  rd_reg;

    logic                       accept;
    logic                       sample;
    logic [fsd_pkg::FILL_W-1:0] idx_ext;
    logic [fsd_pkg::FILL_W-1:0] idx_inc;
    logic                       known;
    logic [fsd_pkg::PIX_W-1:0]  old_pix;

    // Take a new item when stage one is free or moving on
    assign full   = s1_valid_reg && q_full;
    assign accept = push && !full;
    assign sample = accept && (kind == fsd_pkg::KIND_SAMPLE);

    // Entries below the fill count were written since the last restart
    assign idx_ext = {1'b0, point_reg};
    assign idx_inc = idx_ext + 1'b1;
    assign known   = idx_ext < fill_reg;

    // Advance point index and fill count
    always_comb
    begin
        point_next = point_reg;
        fill_next  = fill_reg;
        if (accept)
        begin
            if (kind == fsd_pkg::KIND_RESTART)
            begin
                point_next = '0;
                fill_next  = '0;
            end
            else
            begin
                point_next = last_of_scan ? '0 : idx_inc[fsd_pkg::PT_W-1:0];
                if (idx_inc > fill_reg)
                begin
                    fill_next = idx_inc;
                end
            end
        end
    end

    // Hold stage one while the queue is full
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (!q_full)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg    <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            point_reg    <= point_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_restart_reg <= (kind == fsd_pkg::KIND_RESTART);
            s1_last_reg    <= last_of_scan;
            s1_known_reg   <= known;
            s1_pix_reg     <= pixel_value;
        end
    end

    // Read the old value and store the new one at the same point
    always_ff @(posedge clk)
    begin
        if (sample)
        begin
            rd_reg         <= mem[point_reg];
            mem[point_reg] <= pixel_value;
        end
    end

    // Compare against the stored value, white where never written
    assign old_pix        = s1_known_reg ? rd_reg : fsd_pkg::WHITE565;
    assign q_push         = s1_valid_reg && !q_full;
    assign q_data.restart = s1_restart_reg;
    assign q_data.last    = s1_last_reg;
    assign q_data.match   = (old_pix == s1_pix_reg);

endmodule

@@ sv/fsd_queue.sv @@
// ----------------------------------------------------------------------------
// fsd_queue
// Short register queue of classified words between front and back.
// ----------------------------------------------------------------------------
module fsd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  fsd_pkg::qent_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output fsd_pkg::qent_t rd_data,
    output logic           q_valid
);

    fsd_pkg::qent_t entries [fsd_pkg::QDEPTH];

    logic [fsd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fsd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fsd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_wr;
    logic                       do_rd;

    assign q_full  = (count_reg == fsd_pkg::QCNT_W'(fsd_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_data = entries[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/fsd_back.sv @@
// ----------------------------------------------------------------------------
// fsd_back
// Counts matches per scan, applies the stable-counter rules, detects finish
// and holds the result word until it is popped.
// ----------------------------------------------------------------------------
module fsd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  fsd_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  fsd_pkg::qent_t   q_data,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output fsd_pkg::result_t result
);

    logic [fsd_pkg::MATCH_W-1:0] match_reg, match_next;
    logic [fsd_pkg::STAB_W-1:0]  stab_reg, stab_next;
    logic [fsd_pkg::SCANS_W-1:0] scans_reg, scans_next;
    logic                        done_reg, done_next;
    logic                        out_valid_reg, out_valid_next;
    fsd_pkg::result_t            res_reg, res_next;

    logic                        take;
    logic                        work;
    logic [fsd_pkg::MATCH_W-1:0] match_inc;
    logic                        stable;
    logic [fsd_pkg::STAB_W-1:0]  stab_upd;
    logic [fsd_pkg::SCANS_W-1:0] scans_upd;
    logic                        fin;
    logic [fsd_pkg::SCANS_W-1:0] req_ext;

    // Consume a word whenever the result slot is free or draining
    assign q_pop = q_valid && (!out_valid_reg || pop);
    assign take  = q_pop;
    assign work  = take && !q_data.restart && !done_reg;

    // Per-scan arithmetic
    assign req_ext   = {{(fsd_pkg::SCANS_W-fsd_pkg::STAB_W){1'b0}}, cfg.required_stable};
    assign match_inc = (q_data.match && match_reg != fsd_pkg::MATCH_MAX)
                       ? match_reg + 1'b1 : match_reg;
    assign stable    = match_inc >= cfg.same_threshold;
    assign scans_upd = (scans_reg != fsd_pkg::SCANS_MAX) ? scans_reg + 1'b1 : scans_reg;

    always_comb
    begin
        if (!stable)
        begin
            stab_upd = (stab_reg == '0) ? fsd_pkg::STAB_W'(1) : '0;
        end
        else
        begin
            stab_upd = (stab_reg != fsd_pkg::STAB_MAX) ? stab_reg + 1'b1 : stab_reg;
        end
    end

    assign fin = stable && (stab_upd >= cfg.required_stable);

    // Update scan state
    always_comb
    begin
        match_next = match_reg;
        stab_next  = stab_reg;
        scans_next = scans_reg;
        done_next  = done_reg;
        if (take && q_data.restart)
        begin
            match_next = '0;
            stab_next  = '0;
            scans_next = '0;
            done_next  = 1'b0;
        end
        else if (work)
        begin
            if (q_data.last)
            begin
                match_next = '0;
                stab_next  = stab_upd;
                scans_next = scans_upd;
                done_next  = fin;
            end
            else
            begin
                match_next = match_inc;
            end
        end
    end

    // Load or drain the result slot
    always_comb
    begin
        out_valid_next = out_valid_reg && !pop;
        res_next       = res_reg;
        if (work && q_data.last)
        begin
            out_valid_next        = 1'b1;
            res_next.same_count   = match_inc;
            res_next.scan_stable  = stable;
            res_next.stable_count = stab_upd;
            res_next.finished     = fin;
            res_next.settle_scans = (fin && scans_upd >= req_ext) ? scans_upd - req_ext : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= '0;
            stab_reg      <= '0;
            scans_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            match_reg     <= match_next;
            stab_reg      <= stab_next;
            scans_reg     <= scans_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign empty  = !out_valid_reg;
    assign result = res_reg;

endmodule

@@ verif/frame_stability_detector_chk.sv @@
// ----------------------------------------------------------------------------
// frame_stability_detector_chk
// Watches the sample, result and register channels of the frame stability
// detector. It keeps its own pixel history and counters, works out the
// result of each completed scan, and compares every popped word field by
// field with the oldest outstanding scan result.
// ----------------------------------------------------------------------------
module frame_stability_detector_chk
    import fsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  logic                   kind,
    input  logic [PIX_W-1:0]       pixel_value,
    input  logic                   last_of_scan,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [MATCH_W-1:0]     same_count,
    input  logic                   scan_stable,
    input  logic [STAB_W-1:0]      stable_count,
    input  logic                   finished,
    input  logic [SCANS_W-1:0]     settle_scans,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending,
    output logic                   halted,
    output int                     live_words
);
    timeunit 1ns;
    timeprecision 1ps;

    // Keep the log short when the block is badly off
    localparam int PRINT_LIMIT = 60;

    // Shadow of the detector state
    logic [PIX_W-1:0]   seen_pixel [MAX_POINTS];
    logic [PT_W-1:0]    point;
    logic [MATCH_W-1:0] match_tally;
    logic [STAB_W-1:0]  streak;
    logic [SCANS_W-1:0] scans;
    logic               detected;
    logic [MATCH_W-1:0] threshold;
    logic [STAB_W-1:0]  need;

    result_t scan_reports[$];
    result_t oldest;
    int      err_total  = 0;
    int      live_total = 0;

    // Forget the previous frame: white history, counters cleared
    function automatic void clear_history();
        foreach (seen_pixel[i])
            seen_pixel[i] = WHITE565;
        point       = '0;
        match_tally = '0;
        streak      = '0;
        scans       = '0;
        detected    = 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_total < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
        err_total++;
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %0d got %0d", field, want, got));
    endtask

    // Advance the shadow by one accepted word; queue the scan result it closes
    task automatic judge_word(input logic k, input logic [PIX_W-1:0] pix,
                              input logic lst);
        result_t r;
        if (k == KIND_RESTART)
        begin
            clear_history();
        end
        else if (!detected)
        begin
            if (seen_pixel[point] == pix && match_tally != MATCH_MAX)
                match_tally = match_tally + 1'b1;
            seen_pixel[point] = pix;
            point = point + 1'b1;
            if (lst)
            begin
                r.same_count   = match_tally;
                r.scan_stable  = (match_tally >= threshold);
                r.finished     = 1'b0;
                r.settle_scans = '0;
                match_tally = '0;
                point       = '0;
                if (scans != SCANS_MAX)
                    scans = scans + 1'b1;
                if (!r.scan_stable)
                begin
                    streak = (streak == '0) ? STAB_W'(1) : '0;
                end
                else
                begin
                    if (streak != STAB_MAX)
                        streak = streak + 1'b1;
                    if (streak >= need)
                    begin
                        detected       = 1'b1;
                        r.finished     = 1'b1;
                        r.settle_scans = (scans >= SCANS_W'(need)) ?
                                         scans - SCANS_W'(need) : '0;
                    end
                end
                r.stable_count = streak;
                scan_reports.push_back(r);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_history();
            threshold = THRESHOLD_RESET;
            need      = REQUIRED_RESET;
            scan_reports.delete();
        end
        else
        begin
            // Compare a popped word with the oldest expected scan
            if (pop && !empty)
            begin
                if (scan_reports.size() == 0)
                begin
                    report_mismatch("result word with no scan outstanding");
                end
                else
                begin
                    oldest = scan_reports.pop_front();
                    check_field("same_count", 16'(oldest.same_count), 16'(same_count));
                    check_field("scan_stable", 16'(oldest.scan_stable), 16'(scan_stable));
                    check_field("stable_count", 16'(oldest.stable_count),
                                16'(stable_count));
                    check_field("finished", 16'(oldest.finished), 16'(finished));
                    check_field("settle_scans", oldest.settle_scans, settle_scans);
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SAME_THRESHOLD)
                    threshold = cfg_data[MATCH_W-1:0];
                else if (cfg_index == REG_REQUIRED_STABLE)
                    need = cfg_data[STAB_W-1:0];
            end

            // Predict from each accepted word
            if (push && !full)
            begin
                if (kind == KIND_RESTART || !detected)
                    live_total++;
                judge_word(kind, pixel_value, last_of_scan);
            end
        end
        pending    <= scan_reports.size();
        halted     <= detected;
        live_words <= live_total;
        mismatches <= err_total;
    end

endmodule

@@ verif/frame_stability_detector_tb.sv @@
// ----------------------------------------------------------------------------
// frame_stability_detector_tb
// Stimulus and verdict for the frame stability detector. Directed scans hit
// the power-up registers, a white history after restart, zero threshold and
// zero required count, ignored words after a finish and the register
// extremes; random phases then run well-formed scans of changing frames
// mixed with short scans, stray words and restarts, with random idling on
// both sides, a long receiver hold-off and a stretch with no idling.
// ----------------------------------------------------------------------------
module frame_stability_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsd_pkg::*;

    localparam int RANDOM_ITEMS   = 90;
    localparam int IDLE_PCT       = 25;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WHITE_SCAN     = 16;
    localparam int MAX_SCENE      = 16;
    // Longest correct quiet stretch is the receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  push         = 1'b0;
    logic                  kind         = KIND_SAMPLE;
    logic [PIX_W-1:0]      pixel_value  = '0;
    logic                  last_of_scan = 1'b0;
    logic                  pop          = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_SAME_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    logic                  full;
    logic                  empty;
    logic [MATCH_W-1:0]    same_count;
    logic                  scan_stable;
    logic [STAB_W-1:0]     stable_count;
    logic                  finished;
    logic [SCANS_W-1:0]    settle_scans;
    logic                  cfg_ready;

    int                    mismatches;
    int                    pending;
    logic                  halted;
    int                    live_words;

    logic                  steady        = 1'b0;
    int                    hold_requests = 0;
    logic [PIX_W-1:0]      scene [MAX_SCENE];

    frame_stability_detector dut (.*);

    frame_stability_detector_chk chk (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one word and hold it until the block takes it
    task automatic send_word(input logic k, input logic [PIX_W-1:0] pix, input logic lst);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        kind         <= k;
        pixel_value  <= pix;
        last_of_scan <= lst;
        @(negedge clk);
        while (full)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Scan the current scene, changing some points first
    task automatic send_scan(input int len, input int churn);
        for (int p = 0; p < len; p++)
        begin
            if ($urandom_range(0, 99) < churn)
                scene[p] = 16'($urandom);
            send_word(KIND_SAMPLE, scene[p], p == len - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending, wait for every scan result, let the pipeline empty
    task automatic drain();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Result side: random pops, hold off on request
    initial
    begin : result_sink
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        forever
        begin
            @(posedge clk);
            if (served != hold_requests)
            begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (steady)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // End the run if nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int live_start;
        int npts;
        int churn;
        int scans_left;
        int pick;

        foreach (scene[p])
            scene[p] = WHITE565;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-up registers against a white history
        send_word(KIND_SAMPLE, 16'h0000, 1'b1);
        send_word(KIND_SAMPLE, WHITE565, 1'b0);
        send_word(KIND_SAMPLE, 16'h0000, 1'b1);
        send_word(KIND_SAMPLE, 16'hAAAA, 1'b0);
        send_word(KIND_SAMPLE, 16'h5555, 1'b1);
        send_word(KIND_RESTART, WHITE565, 1'b1);
        // One white scan right after restart: every point matches
        repeat (WHITE_SCAN - 1)
            send_word(KIND_SAMPLE, WHITE565, 1'b0);
        send_word(KIND_SAMPLE, WHITE565, 1'b1);
        drain();

        // Zero threshold and zero required count: first scan finishes
        write_reg(REG_SAME_THRESHOLD, 16'd0);
        write_reg(REG_REQUIRED_STABLE, 16'd0);
        send_word(KIND_SAMPLE, 16'h0F0F, 1'b1);
        // Words after a finish are dropped
        send_word(KIND_SAMPLE, 16'h1234, 1'b0);
        send_word(KIND_SAMPLE, 16'hF0F0, 1'b1);
        send_word(KIND_SAMPLE, 16'h0000, 1'b1);
        send_word(KIND_RESTART, 16'h0000, 1'b0);
        send_word(KIND_SAMPLE, WHITE565, 1'b1);
        drain();

        // Unreachable threshold, largest required count
        write_reg(REG_SAME_THRESHOLD, CFG_DATA_W'(MAX_POINTS));
        write_reg(REG_REQUIRED_STABLE, CFG_DATA_W'(STAB_MAX));
        send_word(KIND_RESTART, 16'h0000, 1'b0);
        repeat (4)
            send_scan(2, 50);
        drain();

        // 258 stable one-point scans with no idling; receiver holds off early
        write_reg(REG_SAME_THRESHOLD, 16'd0);
        send_word(KIND_RESTART, 16'h0000, 1'b0);
        steady        <= 1'b1;
        hold_requests <= hold_requests + 1;
        repeat (int'(STAB_MAX) + 3)
            send_word(KIND_SAMPLE, 16'($urandom), 1'b1);
        steady <= 1'b0;
        drain();

        // Random phases: new settings, restart, mostly well-formed scans
        live_start = live_words;
        while (live_words < live_start + RANDOM_ITEMS)
        begin
            npts  = $urandom_range(1, MAX_SCENE);
            churn = $urandom_range(0, 40);
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SAME_THRESHOLD, CFG_DATA_W'($urandom_range(0, MAX_POINTS)));
            else
                write_reg(REG_SAME_THRESHOLD, CFG_DATA_W'($urandom_range(0, npts)));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_REQUIRED_STABLE, CFG_DATA_W'($urandom_range(1, 255)));
            else
                write_reg(REG_REQUIRED_STABLE, CFG_DATA_W'($urandom_range(1, 6)));
            foreach (scene[p])
                scene[p] = ($urandom_range(0, 3) == 0) ? WHITE565 : 16'($urandom);
            send_word(KIND_RESTART, 16'($urandom), 1'($urandom));

            scans_left = $urandom_range(4, 24);
            while (scans_left > 0 && !halted)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_scan(npts, churn);
                else if (pick < 90)
                    send_scan($urandom_range(1, npts), churn);
                else if (pick < 95)
                    send_word(KIND_SAMPLE, 16'($urandom), $urandom_range(0, 3) == 0);
                else
                begin
                    // Abandon a scan halfway with a restart
                    repeat ($urandom_range(1, npts))
                        send_word(KIND_SAMPLE, 16'($urandom), 1'b0);
                    send_word(KIND_RESTART, 16'($urandom), 1'($urandom));
                end
                scans_left--;
            end

            // Poke a finished detector
            if (halted)
                repeat ($urandom_range(1, 3))
                    send_word(KIND_SAMPLE, 16'($urandom), 1'($urandom));
            drain();
        end

        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
